// File: sv/hkrb_pkg.sv
// Package for the HID keyboard/mouse report builder.
// Holds command and report codes, sizes, handshake structs and the step clamp.
// No dependencies.
package hkrb_pkg;

  localparam int MAX_MOVE_STEPS = 64;
  localparam int STEP_W = (MAX_MOVE_STEPS > 1) ? $clog2(MAX_MOVE_STEPS) : 1;
  localparam int SLOT_COUNT = 6;

  localparam logic [2:0] CMD_KEY_DOWN    = 3'd0;
  localparam logic [2:0] CMD_KEY_UP      = 3'd1;
  localparam logic [2:0] CMD_RELEASE_ALL = 3'd2;
  localparam logic [2:0] CMD_MOVE        = 3'd3;
  localparam logic [2:0] CMD_BUTTONS     = 3'd4;
  localparam logic [2:0] CMD_WHEEL       = 3'd5;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_KBD   = 2'd1;
  localparam logic [1:0] KIND_MOUSE = 2'd2;

  localparam logic       STATUS_OK       = 1'b0;
  localparam logic       STATUS_NO_LINK  = 1'b1;

  localparam logic [7:0] MOD_LO = 8'hE0;
  localparam logic [7:0] MOD_HI = 8'hE7;

  localparam logic signed [13:0] MOVE_SAT = 14'sd8128;
  localparam logic signed [13:0] STEP_LIM = 14'sd127;

  typedef struct packed {
    logic load;
    logic emit;
  } hkrb_cmd_t;

  typedef struct packed {
    logic last;
  } hkrb_stat_t;

  function automatic logic signed [7:0] limit_step(input logic signed [13:0] v);
    logic signed [13:0] c;
    if (v > STEP_LIM) begin
      c = STEP_LIM;
    end else if (v < -STEP_LIM) begin
      c = -STEP_LIM;
    end else begin
      c = v;
    end
    return c[7:0];
  endfunction

endpackage

// File: sv/hkrb_ctrl.sv
// Controller for the HID report builder: idle/work sequencing and output valid.
// Depends on hkrb_pkg.
module hkrb_ctrl
  import hkrb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  hkrb_stat_t dp_stat,
  output hkrb_cmd_t  dp_cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WORK = 1'b1;

  logic state_r, state_nxt;
  logic out_tvalid_r, out_tvalid_nxt;

  always_comb begin
    dp_cmd.load = (state_r == ST_IDLE) && in_tvalid;
    dp_cmd.emit = (state_r == ST_WORK) && (!out_tvalid_r || out_tready);
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_WORK;
      end
      ST_WORK: begin
        if (dp_cmd.emit && dp_stat.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (dp_cmd.emit) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;

endmodule

// File: sv/hkrb_datapath.sv
// Datapath for the HID report builder: input latch, key/modifier/button state,
// move step splitter and output register. Depends on hkrb_pkg.
module hkrb_datapath
  import hkrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [63:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  hkrb_cmd_t   dp_cmd,
  output hkrb_stat_t  dp_stat,
  output logic [63:0] out_tdata,
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);

  logic [2:0]         cmd_r;
  logic               link_r;
  logic [7:0]         usage_r;
  logic signed [13:0] rx_r, ry_r;
  logic [4:0]         mask_r;
  logic [7:0]         wv_r, wh_r;
  logic [STEP_W-1:0]  cnt_r;

  logic [7:0]         mod_r, mod_nxt;
  logic [7:0]         slots_r   [SLOT_COUNT];
  logic [7:0]         slots_nxt [SLOT_COUNT];
  logic [4:0]         held_r, held_nxt;

  logic [63:0]        tdata_r;
  logic [2:0]         tuser_r;
  logic               tlast_r;

  logic signed [13:0] mx_in, my_in, mx_sat, my_sat;
  logic signed [7:0]  sx, sy;
  logic signed [13:0] rx_step, ry_step;
  logic               is_mod, present, found;
  logic [7:0]         mod_bit;
  logic [SLOT_COUNT-1:0] match, free;
  logic [7:0]         rep [8];
  logic [63:0]        rep_data;
  logic [1:0]         kind;
  logic               status;
  logic               last;

  assign mx_in  = in_tdata[22:9];
  assign my_in  = in_tdata[36:23];
  assign mx_sat = (mx_in > MOVE_SAT) ? MOVE_SAT : ((mx_in < -MOVE_SAT) ? -MOVE_SAT : mx_in);
  assign my_sat = (my_in > MOVE_SAT) ? MOVE_SAT : ((my_in < -MOVE_SAT) ? -MOVE_SAT : my_in);

  always_comb begin
    sx      = limit_step(rx_r);
    sy      = limit_step(ry_r);
    rx_step = rx_r - 14'(sx);
    ry_step = ry_r - 14'(sy);
    is_mod  = (usage_r >= MOD_LO) && (usage_r <= MOD_HI);
    mod_bit = 8'b1 << usage_r[2:0];
    for (int i = 0; i < SLOT_COUNT; i++) begin
      match[i] = (slots_r[i] == usage_r);
      free[i]  = (slots_r[i] == 8'd0) && !match[i];
    end
    present = |match;

    mod_nxt  = mod_r;
    held_nxt = held_r;
    for (int i = 0; i < SLOT_COUNT; i++) slots_nxt[i] = slots_r[i];
    kind   = KIND_NONE;
    status = STATUS_OK;
    last   = 1'b1;
    found  = 1'b0;

    if (cmd_r > CMD_WHEEL) begin
      kind = KIND_NONE;
    end else if (!link_r) begin
      status = STATUS_NO_LINK;
    end else begin
      unique case (cmd_r)
        CMD_KEY_DOWN: begin
          if (is_mod) begin
            mod_nxt = mod_r | mod_bit;
            kind    = KIND_KBD;
          end else if (present) begin
            kind = KIND_KBD;
          end else if (|free) begin
            kind = KIND_KBD;
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (free[i] && !found) begin
                slots_nxt[i] = usage_r;
                found        = 1'b1;
              end
            end
          end
        end
        CMD_KEY_UP: begin
          kind = KIND_KBD;
          if (is_mod) begin
            mod_nxt = mod_r & ~mod_bit;
          end else begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (match[i]) slots_nxt[i] = 8'd0;
            end
          end
        end
        CMD_RELEASE_ALL: begin
          mod_nxt  = 8'd0;
          held_nxt = 5'd0;
          for (int i = 0; i < SLOT_COUNT; i++) slots_nxt[i] = 8'd0;
          if (cnt_r == '0) begin
            kind = KIND_KBD;
            last = 1'b0;
          end else begin
            kind = KIND_MOUSE;
          end
        end
        CMD_MOVE: begin
          if (rx_r != 14'sd0 || ry_r != 14'sd0) begin
            kind = KIND_MOUSE;
            last = ((rx_step == 14'sd0) && (ry_step == 14'sd0)) ||
                   (cnt_r == STEP_W'(MAX_MOVE_STEPS - 1));
          end
        end
        CMD_BUTTONS: begin
          if (mask_r != held_r) begin
            held_nxt = mask_r;
            kind     = KIND_MOUSE;
          end
        end
        CMD_WHEEL: begin
          kind = KIND_MOUSE;
        end
        default: kind = KIND_NONE;
      endcase
    end

    for (int i = 0; i < 8; i++) rep[i] = 8'd0;
    if (kind == KIND_KBD) begin
      rep[0] = mod_nxt;
      for (int i = 0; i < SLOT_COUNT; i++) rep[2+i] = slots_nxt[i];
    end else if (kind == KIND_MOUSE) begin
      rep[0] = {3'b000, held_nxt};
      if (cmd_r == CMD_MOVE) begin
        rep[1] = sx;
        rep[2] = sy;
      end else if (cmd_r == CMD_WHEEL) begin
        rep[3] = wv_r;
        rep[4] = wh_r;
      end
    end
    for (int i = 0; i < 8; i++) rep_data[8*i +: 8] = rep[i];
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_r   <= in_tuser;
      link_r  <= in_tdata[0];
      usage_r <= in_tdata[8:1];
      rx_r    <= mx_sat;
      ry_r    <= my_sat;
      mask_r  <= in_tdata[41:37];
      wv_r    <= in_tdata[52:45];
      wh_r    <= in_tdata[60:53];
    end else if (dp_cmd.emit) begin
      rx_r <= rx_step;
      ry_r <= ry_step;
    end
    if (dp_cmd.emit) begin
      tdata_r <= rep_data;
      tuser_r <= {status, kind};
      tlast_r <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      mod_r  <= 8'd0;
      held_r <= 5'd0;
      for (int i = 0; i < SLOT_COUNT; i++) slots_r[i] <= 8'd0;
    end else begin
      if (dp_cmd.load) begin
        cnt_r <= '0;
      end else if (dp_cmd.emit) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (dp_cmd.emit) begin
        mod_r  <= mod_nxt;
        held_r <= held_nxt;
        for (int i = 0; i < SLOT_COUNT; i++) slots_r[i] <= slots_nxt[i];
      end
    end
  end

  assign dp_stat.last = last;
  assign out_tdata    = tdata_r;
  assign out_tuser    = tuser_r;
  assign out_tlast    = tlast_r;

endmodule

// File: sv/hid_keyboard_mouse_report_builder_top.sv
// HID keyboard/mouse report builder, top level. A command is latched into the
// datapath input registers, then its first report into the output register once
// that register is free. One report per cycle while the output is taken; a
// command yields 1 to 64 reports and holds off the next command until its last
// report is registered. Reset (rst_n low, synchronous) clears modifiers, key slots,
// buttons and all handshake state. Depends on hkrb_pkg, hkrb_ctrl, hkrb_datapath.
module hid_keyboard_mouse_report_builder_top
  import hkrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] link_up, [8:1] usage, [22:9] move_x, [36:23] move_y,
  // [41:37] button_mask, [52:45] wheel_vertical, [60:53] wheel_horizontal
  input  logic [63:0] in_tdata,
  // [2:0] command
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] report_byte0 ... [63:56] report_byte7
  output logic [63:0] out_tdata,
  // [1:0] report_kind, [2] status
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);

  hkrb_cmd_t  dp_cmd;
  hkrb_stat_t dp_stat;

  hkrb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .dp_stat    (dp_stat),
    .dp_cmd     (dp_cmd)
  );

  hkrb_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while previous item still in work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.emit |-> !(out_tvalid && !out_tready))
    else $error("result register overwritten while waiting");

  a_load_emit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(dp_cmd.load && dp_cmd.emit))
    else $error("load and emit in the same cycle");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1:0] == KIND_NONE) |-> (out_tdata == 64'd0 && out_tlast))
    else $error("empty result carries data or is not last");

endmodule

// File: dv/hid_keyboard_mouse_report_builder_top_tb.sv
// Self-checking testbench for hid_keyboard_mouse_report_builder_top: directed
// table then random commands, reports checked against an in-bench predictor or,
// for some directed rows, a fixed expected report. Depends on hkrb_pkg and the report builder RTL.
module hid_keyboard_mouse_report_builder_top_tb
  import hkrb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED_7 = 3'd7;
  localparam int RANDOM_ITEMS = 270;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef enum logic {FROM_MODEL, FIXED} row_check_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic               link;
    logic [7:0]         usage;
    logic signed [13:0] mx;
    logic signed [13:0] my;
    logic [7:0]         btn;
    logic signed [7:0]  wv;
    logic signed [7:0]  wh;
  } stim_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        status;
    logic [63:0] bytes;
    logic        last;
  } report_t;

  typedef struct packed {
    stim_item_t item;
    row_check_e chk;
    report_t    rep;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  // predictor state
  logic [7:0] kb_mods;
  logic [7:0] kb_slots [SLOT_COUNT];
  logic [4:0] mouse_btns;

  report_t  step_reports [MAX_MOVE_STEPS];
  int       step_n;
  report_t  pending_reports [$];
  dir_row_t directed_rows [$];

  int mismatches;
  int cycles;
  bit send_burst;
  bit recv_burst;
  bit hold_request;

  hid_keyboard_mouse_report_builder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int clamp_to(input int v, input int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic report_t empty_report(input logic st);
    report_t r;
    r.kind   = KIND_NONE;
    r.status = st;
    r.bytes  = '0;
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic report_t kbd_report();
    report_t r;
    r.kind   = KIND_KBD;
    r.status = STATUS_OK;
    r.bytes  = {kb_slots[5], kb_slots[4], kb_slots[3], kb_slots[2],
                kb_slots[1], kb_slots[0], 8'h00, kb_mods};
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic report_t mouse_report(input int dx, input int dy, input int wh,
                                           input int pan);
    report_t r;
    r.kind   = KIND_MOUSE;
    r.status = STATUS_OK;
    r.bytes  = {24'h0, pan[7:0], wh[7:0], dy[7:0], dx[7:0], 3'b000, mouse_btns};
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic void add_report(input report_t r);
    step_reports[step_n] = r;
    step_n++;
  endfunction

  // Updates the held keys/buttons and fills step_reports for one item.
  function automatic void build_reports(input stim_item_t it);
    logic [7:0] mbit;
    logic       is_mod;
    logic       present;
    int         free_at;
    int         rx, ry, sx, sy;
    step_n = 0;
    mbit   = 8'h01 << it.usage[2:0];
    is_mod = (it.usage >= MOD_LO) && (it.usage <= MOD_HI);
    if (it.cmd > CMD_WHEEL) begin
      add_report(empty_report(STATUS_OK));
    end else if (!it.link) begin
      add_report(empty_report(STATUS_NO_LINK));
    end else begin
      case (it.cmd)
        CMD_KEY_DOWN: begin
          if (is_mod) begin
            kb_mods |= mbit;
            add_report(kbd_report());
          end else begin
            present = 1'b0;
            free_at = -1;
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (kb_slots[i] == it.usage) present = 1'b1;
              else if (kb_slots[i] == 8'h00 && free_at < 0) free_at = i;
            end
            if (present) begin
              add_report(kbd_report());
            end else if (free_at < 0) begin
              add_report(empty_report(STATUS_OK));
            end else begin
              kb_slots[free_at] = it.usage;
              add_report(kbd_report());
            end
          end
        end
        CMD_KEY_UP: begin
          if (is_mod) begin
            kb_mods &= ~mbit;
          end else begin
            for (int i = 0; i < SLOT_COUNT; i++)
              if (kb_slots[i] == it.usage) kb_slots[i] = 8'h00;
          end
          add_report(kbd_report());
        end
        CMD_RELEASE_ALL: begin
          kb_mods    = '0;
          mouse_btns = '0;
          for (int i = 0; i < SLOT_COUNT; i++) kb_slots[i] = 8'h00;
          add_report(kbd_report());
          add_report(mouse_report(0, 0, 0, 0));
        end
        CMD_MOVE: begin
          rx = clamp_to(int'(it.mx), int'(MOVE_SAT));
          ry = clamp_to(int'(it.my), int'(MOVE_SAT));
          while ((rx != 0 || ry != 0) && step_n < MAX_MOVE_STEPS) begin
            sx = clamp_to(rx, 127);
            sy = clamp_to(ry, 127);
            add_report(mouse_report(sx, sy, 0, 0));
            rx -= sx;
            ry -= sy;
          end
          if (step_n == 0) add_report(empty_report(STATUS_OK));
        end
        CMD_BUTTONS: begin
          if (it.btn[4:0] != mouse_btns) begin
            mouse_btns = it.btn[4:0];
            add_report(mouse_report(0, 0, 0, 0));
          end else begin
            add_report(empty_report(STATUS_OK));
          end
        end
        default: begin
          add_report(mouse_report(0, 0, int'(it.wv), int'(it.wh)));
        end
      endcase
    end
  endfunction

  function automatic void add_row(input logic [2:0] cmd, input logic link,
                                  input logic [7:0] usage, input int mx, input int my,
                                  input logic [7:0] btn, input int wv, input int wh,
                                  input row_check_e chk, input logic [1:0] kind,
                                  input logic st, input logic [63:0] bytes);
    dir_row_t row;
    row.item.cmd   = cmd;
    row.item.link  = link;
    row.item.usage = usage;
    row.item.mx    = 14'(mx);
    row.item.my    = 14'(my);
    row.item.btn   = btn;
    row.item.wv    = 8'(wv);
    row.item.wh    = 8'(wh);
    row.chk        = chk;
    row.rep.kind   = kind;
    row.rep.status = st;
    row.rep.bytes  = bytes;
    row.rep.last   = 1'b1;
    directed_rows.push_back(row);
  endfunction

  function automatic stim_item_t random_item();
    stim_item_t it;
    int         pick;
    it.cmd   = 3'($urandom);
    it.usage = 8'($urandom);
    it.mx    = 14'($urandom);
    it.my    = 14'($urandom);
    it.btn   = 8'($urandom);
    it.wv    = 8'($urandom);
    it.wh    = 8'($urandom);
    it.link  = ($urandom_range(0, 15) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 34)      it.cmd = CMD_KEY_DOWN;
    else if (pick < 58) it.cmd = CMD_KEY_UP;
    else if (pick < 63) it.cmd = CMD_RELEASE_ALL;
    else if (pick < 78) it.cmd = CMD_MOVE;
    else if (pick < 88) it.cmd = CMD_BUTTONS;
    else if (pick < 96) it.cmd = CMD_WHEEL;
    else                it.cmd = $urandom_range(0, 1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
    case (it.cmd)
      CMD_KEY_DOWN, CMD_KEY_UP: begin
        pick = $urandom_range(0, 9);
        if (pick < 2)       it.usage = MOD_LO + 8'($urandom_range(0, 7));
        else if (pick < 8)  it.usage = 8'h04 + 8'($urandom_range(0, 9));
        else if (pick == 8) it.usage = 8'h00;
      end
      CMD_MOVE: begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          it.mx = 14'(int'($urandom_range(0, 600)) - 300);
          it.my = 14'(int'($urandom_range(0, 600)) - 300);
        end else if (pick < 9) begin
          it.mx = 14'(int'($urandom_range(0, 5000)) - 2500);
          it.my = 14'(int'($urandom_range(0, 5000)) - 2500);
        end
        if ($urandom_range(0, 5) == 0) it.mx = '0;
        if ($urandom_range(0, 5) == 0) it.my = '0;
      end
      CMD_BUTTONS: begin
        if ($urandom_range(0, 1) == 0) it.btn = {it.btn[7:5], mouse_btns};
      end
      default: ;
    endcase
    return it;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // Entered and left at a falling edge; valid stays high only if the next item follows.
  task automatic send_item(input stim_item_t it, input row_check_e chk,
                           input report_t fixed_rep);
    int      gap;
    report_t r;
    gap = send_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.cmd;
    in_tdata  <= {3'b000, it.wh, it.wv, it.btn, it.my, it.mx, it.usage, it.link};
    do @(posedge clk); while (!in_tready);
    build_reports(it);
    if (chk == FIXED) begin
      pending_reports.push_back(fixed_rep);
    end else begin
      for (int i = 0; i < step_n; i++) begin
        r = step_reports[i];
        r.last = (i == step_n - 1);
        pending_reports.push_back(r);
      end
    end
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reports.size() == 0) begin
        note_mismatch($sformatf("unexpected report: kind %0d status %0d data %h last %0b",
                                out_tuser[1:0], out_tuser[2], out_tdata, out_tlast));
      end else begin
        want = pending_reports.pop_front();
        if (out_tuser[1:0] !== want.kind || out_tuser[2] !== want.status ||
            out_tdata !== want.bytes || out_tlast !== want.last) begin
          note_mismatch($sformatf(
            "report mismatch: expected kind %0d status %0d data %h last %0b, got %0d %0d %h %0b",
            want.kind, want.status, want.bytes, want.last,
            out_tuser[1:0], out_tuser[2], out_tdata, out_tlast));
        end
      end
    end
  end

  // receiver
  initial begin
    int stall;
    int taken;
    out_tready = 1'b0;
    taken = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (taken % 40 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      taken++;
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      stall = recv_burst ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // sender and run control
  initial begin
    stim_item_t it;
    report_t    unused_rep;
    int         hold_at;
    int         pause_at;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    mismatches = 0;
    kb_mods    = '0;
    mouse_btns = '0;
    unused_rep = '0;
    for (int i = 0; i < SLOT_COUNT; i++) kb_slots[i] = 8'h00;

    // nothing held after reset
    add_row(CMD_KEY_UP, 1, 8'h04, 0, 0, 0, 0, 0, FIXED, KIND_KBD, STATUS_OK, '0);
    add_row(CMD_KEY_DOWN, 0, 8'h04, 0, 0, 0, 0, 0, FIXED, KIND_NONE, STATUS_NO_LINK, '0);
    add_row(CMD_MOVE, 0, 8'h00, 100, -100, 0, 0, 0, FIXED, KIND_NONE, STATUS_NO_LINK, '0);
    add_row(CMD_UNUSED_6, 1, 8'h04, 0, 0, 0, 0, 0, FIXED, KIND_NONE, STATUS_OK, '0);
    add_row(CMD_UNUSED_7, 0, 8'h04, 0, 0, 0, 0, 0, FIXED, KIND_NONE, STATUS_OK, '0);
    add_row(CMD_KEY_DOWN, 1, MOD_LO, 0, 0, 0, 0, 0, FROM_MODEL, KIND_NONE, STATUS_OK, '0);
    add_row(CMD_KEY_DOWN, 1, MOD_HI, 0, 0, 0, 0, 0, FROM_MODEL, KIND_NONE, STATUS_OK, '0);
    add_row(CMD_KEY_DOWN, 1, 8'h00, 0, 0, 0, 0, 0, FROM_MODEL, KIND_NONE, STATUS_OK, '0);
    for (int k = 0; k < SLOT_COUNT; k++)
      add_row(CMD_KEY_DOWN, 1, 8'(8'h04 + k), 0, 0, 0, 0, 0, FROM_MODEL, KIND_NONE,
              STATUS_OK, '0);
    add_row(CMD_KEY_DOWN, 1, 8'h04, 0, 0, 0, 0, 0, FROM_MODEL, KIND_NONE, STATUS_OK, '0);
    // slots full: new keys dropped
    add_row(CMD_KEY_DOWN, 1, 8'h00, 0, 0, 0, 0, 0, FIXED, KIND_NONE, STATUS_OK, '0);
    add_row(CMD_KEY_DOWN, 1, 8'hFF, 0, 0, 0, 0, 0, FIXED, KIND_NONE, STATUS_OK, '0);
    add_row(CMD_KEY_UP, 1, 8'h00, 0, 0, 0, 0, 0, FROM_MODEL, KIND_NONE, STATUS_OK, '0);
    add_row(CMD_KEY_UP, 1, 8'h06, 0, 0, 0, 0, 0, FROM_MODEL, KIND_NONE, STATUS_OK, '0);
    add_row(CMD_KEY_DOWN, 1, 8'hFF, 0, 0, 0, 0, 0, FROM_MODEL, KIND_NONE, STATUS_OK, '0);
    add_row(CMD_KEY_UP, 1, MOD_LO, 0, 0, 0, 0, 0, FROM_MODEL, KIND_NONE, STATUS_OK, '0);
    add_row(CMD_BUTTONS, 1, 8'h00, 0, 0, 8'hFF, 0, 0, FROM_MODEL, KIND_NONE, STATUS_OK, '0);
    add_row(CMD_BUTTONS, 1, 8'h00, 0, 0, 8'h1F, 0, 0, FIXED, KIND_NONE, STATUS_OK, '0);
    add_row(CMD_MOVE, 1, 8'h00, 0, 0, 0, 0, 0, FIXED, KIND_NONE, STATUS_OK, '0);
    add_row(CMD_MOVE, 1, 8'h00, 8191, -8192, 0, 0, 0, FROM_MODEL, KIND_NONE, STATUS_OK, '0);
    add_row(CMD_MOVE, 1, 8'h00, 1, -1, 0, 0, 0, FROM_MODEL, KIND_NONE, STATUS_OK, '0);
    add_row(CMD_WHEEL, 1, 8'h00, 0, 0, 0, 127, -128, FROM_MODEL, KIND_NONE, STATUS_OK, '0);
    add_row(CMD_RELEASE_ALL, 1, 8'h00, 0, 0, 0, 0, 0, FROM_MODEL, KIND_NONE, STATUS_OK, '0);
    add_row(CMD_BUTTONS, 1, 8'h00, 0, 0, 8'hE0, 0, 0, FIXED, KIND_NONE, STATUS_OK, '0);
    add_row(CMD_WHEEL, 1, 8'h00, 0, 0, 0, -128, 127, FROM_MODEL, KIND_NONE, STATUS_OK, '0);
    add_row(CMD_MOVE, 1, 8'h00, 8128, 5, 0, 0, 0, FROM_MODEL, KIND_NONE, STATUS_OK, '0);

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_burst = 1'b0;
    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].chk, directed_rows[i].rep);

    hold_at  = $urandom_range(60, 160);
    pause_at = $urandom_range(180, 260);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 32 == 0) send_burst = ($urandom_range(0, 3) == 0);
      if (n == hold_at) hold_request = 1'b1;
      if (n == pause_at) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_reports.size() != 0) @(negedge clk);
      end
      it = random_item();
      send_item(it, FROM_MODEL, unused_rep);
    end
    in_tvalid <= 1'b0;

    while (pending_reports.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
